### hw/rtl/bitmap_glyph_renderer_macros.svh
// ----------------------------------------------------------------------------
// Bitmap glyph renderer assertion macros
// Shorthand for clocked properties that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef BITMAP_GLYPH_RENDERER_MACROS_SVH
`define BITMAP_GLYPH_RENDERER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BGR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bgr_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap glyph renderer package
// Sizes, command and register codes, and shared types of the renderer.
// ----------------------------------------------------------------------------
package bgr_pkg;

    localparam int FONT_BYTES = 32768;
    localparam int FONT_AW    = $clog2(FONT_BYTES);
    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 32;

    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 2;
    localparam int COORD_W    = 12;
    localparam int CODE_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int ROW_BITS_W = 32;
    localparam int SWIDTH_W   = 16;
    localparam int HEIGHT_W   = 6;
    localparam int GAP_W      = 3;
    localparam int STRIDE_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Glyph byte address: code times stride plus the record offset.
    localparam int ADDR_W     = CODE_W + STRIDE_W + 1;
    localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
    localparam int BPR_W      = 3;
    localparam int BCNT_W     = 2;
    localparam int ADV_W      = WIDTH_W + 1;
    localparam int KEEP_W     = 4;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CURSOR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd2;

    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 6'd16;
    localparam logic [GAP_W-1:0]    RST_GAP    = 3'd1;
    localparam logic [STRIDE_W-1:0] RST_STRIDE = 8'd33;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [GAP_W-1:0]    gap;
        logic [STRIDE_W-1:0] stride;
    } cfg_t;

    typedef struct packed {
        logic               en;
        logic [FONT_AW-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } font_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } font_rd_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } shift_ctl_t;

    // Mask that keeps the lowest keep bits of a font byte, keep from 0 to 8.
    function automatic logic [BYTE_W-1:0] byte_mask(input logic [KEEP_W-1:0] keep);
        logic [BYTE_W-1:0] m;
        begin
            m = {BYTE_W{1'b1}} >> (KEEP_W'(BYTE_W) - keep);
            return m;
        end
    endfunction

endpackage

### hw/rtl/bgr_if.sv
// ----------------------------------------------------------------------------
// Bitmap glyph renderer channels
// Valid/ready channels for command items and for rendered glyph rows.
// ----------------------------------------------------------------------------
interface bgr_cmd_if;
    import bgr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic [CODE_W-1:0]    char_code;
    logic [COLOR_W-1:0]   ink_color;
    logic [FONT_AW-1:0]   font_addr;
    logic [BYTE_W-1:0]    font_byte;

    modport source (
        output valid, command, start_x, start_y, char_code, ink_color, font_addr,
               font_byte,
        input  ready
    );

    modport sink (
        input  valid, command, start_x, start_y, char_code, ink_color, font_addr,
               font_byte,
        output ready
    );
endinterface

interface bgr_row_if;
    import bgr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_W-1:0]    row_x;
    logic [COORD_W-1:0]    row_y;
    logic [ROW_BITS_W-1:0] row_bits;
    logic [COLOR_W-1:0]    row_color;
    logic [SWIDTH_W-1:0]   string_width;
    logic                  last_row;

    modport source (
        output valid, row_x, row_y, row_bits, row_color, string_width, last_row,
        input  ready
    );

    modport sink (
        input  valid, row_x, row_y, row_bits, row_color, string_width, last_row,
        output ready
    );
endinterface

### hw/rtl/bitmap_glyph_renderer.sv
// Load and set-cursor commands complete at once; the block is ready again next cycle.
// A draw reads the width byte, then per glyph row fetches the row bytes, flushes and
// emits the row, waiting while the output stalls; a zero-width glyph only emits rows,
// and a zero height emits none. The single font read port, one byte per cycle, paces it.
// Reset clears the pen, the running width, the output valid and the sequencer; the font
// memory is not cleared and holds unknown data until loaded.
// ----------------------------------------------------------------------------
// Bitmap glyph renderer
// Proportional bitmap font character generator with a byte-serial glyph fetch.
// ----------------------------------------------------------------------------
module bitmap_glyph_renderer (
    input  logic                            clk,
    input  logic                            rst_n,
    bgr_cmd_if.sink                         cmd,
    bgr_row_if.source                       rows,
    input  logic                            cfg_we,
    input  logic [bgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bgr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bgr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BASE  = 6'b000010,
        S_WIDTH = 6'b000100,
        S_ROW   = 6'b001000,
        S_FLUSH = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    cfg_t       cfg;
    font_wr_t   wr;
    font_rd_t   rd;
    shift_ctl_t sctl;
    logic [BYTE_W-1:0]     rd_data;
    logic [ROW_BITS_W-1:0] row_bits_w;

    logic [COORD_W-1:0]  pen_x_reg, pen_x_next;
    logic [COORD_W-1:0]  pen_y_reg, pen_y_next;
    logic [SWIDTH_W-1:0] wtot_reg, wtot_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                out_vld_reg, out_vld_next;

    logic [ADDR_W-2:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic [HEIGHT_W-1:0] h_reg, h_next;
    logic [WIDTH_W-1:0]  w_reg, w_next;
    logic [BPR_W-1:0]    bpr_reg, bpr_next;
    logic [HEIGHT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [BCNT_W-1:0]   byte_cnt_reg, byte_cnt_next;
    logic [COORD_W-1:0]  row_x_reg, row_x_next;
    logic [COORD_W-1:0]  row_y_reg, row_y_next;

    logic [COORD_W-1:0]    o_x_reg, o_x_next;
    logic [COORD_W-1:0]    o_y_reg, o_y_next;
    logic [ROW_BITS_W-1:0] o_bits_reg, o_bits_next;
    logic [COLOR_W-1:0]    o_color_reg, o_color_next;
    logic [SWIDTH_W-1:0]   o_sw_reg, o_sw_next;
    logic                  o_last_reg, o_last_next;

    logic                  accept;
    logic                  out_free;
    logic                  last;
    logic [WIDTH_W-1:0]    w_now;
    logic [BPR_W-1:0]      bpr_now;
    logic [ADV_W-1:0]      adv;
    logic [SWIDTH_W:0]     wsum;
    logic [BPR_W:0]        bpr_sum;

    bgr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgr_font_store u_font (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    bgr_row_shift u_shift (
        .clk   (clk),
        .ctl   (sctl),
        .width ((state_reg == S_WIDTH) ? w_now : w_reg),
        .bpr   (bpr_reg),
        .din   (rd_data),
        .bits  (row_bits_w)
    );

    assign accept   = cmd.valid && cmd.ready;
    assign out_free = !out_vld_reg || rows.ready;
    assign last     = ((row_cnt_reg + HEIGHT_W'(1)) == h_reg);

    // Width byte of the glyph record, clamped, and what follows from it.
    assign w_now   = (rd_data > BYTE_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                    : rd_data[WIDTH_W-1:0];
    assign bpr_sum = (BPR_W+1)'((ADV_W'(w_now) + ADV_W'(7)) >> 3);
    assign bpr_now = bpr_sum[BPR_W-1:0];
    assign adv     = ADV_W'(w_now) + ADV_W'(cfg.gap);
    assign wsum    = (SWIDTH_W+1)'(wtot_reg) + (SWIDTH_W+1)'(adv);

    assign wr.en   = accept && (cmd.command == CMD_LOAD);
    assign wr.addr = cmd.font_addr;
    assign wr.data = cmd.font_byte;

    assign rd.en   = (state_reg == S_BASE) || (state_reg == S_ROW);
    assign rd.addr = (state_reg == S_BASE) ? ADDR_W'(base_reg) : addr_reg;

    assign sctl.clear = (state_reg == S_WIDTH)
                     || ((state_reg == S_EMIT) && out_free && !last);
    assign sctl.shift = rd_vld_reg;

    always_comb
    begin
        state_next    = state_reg;
        pen_x_next    = pen_x_reg;
        pen_y_next    = pen_y_reg;
        wtot_next     = wtot_reg;
        rd_vld_next   = (state_reg == S_ROW);
        out_vld_next  = out_vld_reg && !rows.ready;
        base_next     = base_reg;
        addr_next     = addr_reg;
        color_next    = color_reg;
        h_next        = h_reg;
        w_next        = w_reg;
        bpr_next      = bpr_reg;
        row_cnt_next  = row_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        row_x_next    = row_x_reg;
        row_y_next    = row_y_reg;
        o_x_next      = o_x_reg;
        o_y_next      = o_y_reg;
        o_bits_next   = o_bits_reg;
        o_color_next  = o_color_reg;
        o_sw_next     = o_sw_reg;
        o_last_next   = o_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.command == CMD_CURSOR))
                begin
                    pen_x_next = cmd.start_x;
                    pen_y_next = cmd.start_y;
                    wtot_next  = '0;
                end
                else if (accept && (cmd.command == CMD_DRAW))
                begin
                    base_next  = (ADDR_W-1)'(cmd.char_code) * (ADDR_W-1)'(cfg.stride);
                    color_next = cmd.ink_color;
                    h_next     = (cfg.height > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT)
                                                                      : cfg.height;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                addr_next  = ADDR_W'(base_reg) + ADDR_W'(1);
                state_next = S_WIDTH;
            end
            S_WIDTH:
            begin
                w_next        = w_now;
                bpr_next      = bpr_now;
                row_x_next    = pen_x_reg;
                row_y_next    = pen_y_reg;
                pen_x_next    = pen_x_reg + COORD_W'(adv);
                wtot_next     = wsum[SWIDTH_W] ? '1 : wsum[SWIDTH_W-1:0];
                row_cnt_next  = '0;
                byte_cnt_next = '0;
                if (h_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (bpr_now == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                addr_next     = addr_reg + ADDR_W'(1);
                byte_cnt_next = byte_cnt_reg + BCNT_W'(1);
                if ((BPR_W'(byte_cnt_reg) + BPR_W'(1)) == bpr_reg)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    o_x_next     = row_x_reg;
                    o_y_next     = row_y_reg;
                    o_bits_next  = row_bits_w;
                    o_color_next = color_reg;
                    o_sw_next    = wtot_reg;
                    o_last_next  = last;
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_cnt_next  = row_cnt_reg + HEIGHT_W'(1);
                        row_y_next    = row_y_reg + COORD_W'(1);
                        byte_cnt_next = '0;
                        state_next    = (bpr_reg == '0) ? S_EMIT : S_ROW;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            wtot_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
            wtot_reg    <= wtot_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        addr_reg     <= addr_next;
        color_reg    <= color_next;
        h_reg        <= h_next;
        w_reg        <= w_next;
        bpr_reg      <= bpr_next;
        row_cnt_reg  <= row_cnt_next;
        byte_cnt_reg <= byte_cnt_next;
        row_x_reg    <= row_x_next;
        row_y_reg    <= row_y_next;
        o_x_reg      <= o_x_next;
        o_y_reg      <= o_y_next;
        o_bits_reg   <= o_bits_next;
        o_color_reg  <= o_color_next;
        o_sw_reg     <= o_sw_next;
        o_last_reg   <= o_last_next;
    end

    assign cmd.ready         = (state_reg == S_IDLE);
    assign rows.valid        = out_vld_reg;
    assign rows.row_x        = o_x_reg;
    assign rows.row_y        = o_y_reg;
    assign rows.row_bits     = o_bits_reg;
    assign rows.row_color    = o_color_reg;
    assign rows.string_width = o_sw_reg;
    assign rows.last_row     = o_last_reg;

endmodule

### hw/rtl/bgr_cfg_regs.sv
// ----------------------------------------------------------------------------
// Bitmap glyph renderer configuration registers
// Glyph height, character gap and glyph record stride, written by index.
// ----------------------------------------------------------------------------
module bgr_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bgr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bgr_pkg::cfg_t                   cfg
);
    import bgr_pkg::*;

    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [GAP_W-1:0]    gap_reg, gap_next;
    logic [STRIDE_W-1:0] stride_reg, stride_next;

    always_comb
    begin
        height_next = height_reg;
        gap_next    = gap_reg;
        stride_next = stride_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
                CFG_GAP:    gap_next    = cfg_data[GAP_W-1:0];
                CFG_STRIDE: stride_next = cfg_data[STRIDE_W-1:0];
                default:
                begin
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= RST_HEIGHT;
            gap_reg    <= RST_GAP;
            stride_reg <= RST_STRIDE;
        end
        else
        begin
            height_reg <= height_next;
            gap_reg    <= gap_next;
            stride_reg <= stride_next;
        end
    end

    assign cfg.height = height_reg;
    assign cfg.gap    = gap_reg;
    assign cfg.stride = stride_reg;

endmodule

### hw/rtl/bgr_font_store.sv
// ----------------------------------------------------------------------------
// Bitmap glyph renderer font store
// Byte-wide font memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bgr_font_store (
    input  logic                        clk,
    input  bgr_pkg::font_wr_t           wr,
    input  bgr_pkg::font_rd_t           rd,
    output logic [bgr_pkg::BYTE_W-1:0]  rd_data
);
    import bgr_pkg::*;

    logic [BYTE_W-1:0] font_mem [FONT_BYTES];
    logic [BYTE_W-1:0] data_reg;
    logic              oob_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            font_mem[wr.addr] <= wr.data;
        end
    end

    // Addresses past the end of the memory read back as zero.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            data_reg <= font_mem[rd.addr[FONT_AW-1:0]];
            oob_reg  <= (rd.addr >= ADDR_W'(FONT_BYTES));
        end
    end

    assign rd_data = oob_reg ? '0 : data_reg;

endmodule

### hw/rtl/bgr_row_shift.sv
// ----------------------------------------------------------------------------
// Bitmap glyph renderer row shifter
// Assembles one glyph row a byte per cycle while shift is asserted, trimming pixels past the width.
// ----------------------------------------------------------------------------
module bgr_row_shift (
    input  logic                            clk,
    input  bgr_pkg::shift_ctl_t             ctl,
    input  logic [bgr_pkg::WIDTH_W-1:0]     width,
    input  logic [bgr_pkg::BPR_W-1:0]       bpr,
    input  logic [bgr_pkg::BYTE_W-1:0]      din,
    output logic [bgr_pkg::ROW_BITS_W-1:0]  bits
);
    import bgr_pkg::*;

    logic [WIDTH_W-1:0]    rem_reg, rem_next;
    logic [ROW_BITS_W-1:0] sh_reg, sh_next;
    logic [KEEP_W-1:0]     keep;

    assign keep = (rem_reg >= WIDTH_W'(BYTE_W)) ? KEEP_W'(BYTE_W) : rem_reg[KEEP_W-1:0];

    // Bytes enter at the top, so the first byte of the row ends lowest.
    always_comb
    begin
        rem_next = rem_reg;
        sh_next  = sh_reg;
        if (ctl.clear)
        begin
            rem_next = width;
        end
        else if (ctl.shift)
        begin
            rem_next = rem_reg - WIDTH_W'(keep);
            sh_next  = {din & byte_mask(keep), sh_reg[ROW_BITS_W-1:BYTE_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    always_comb
    begin
        case (bpr)
            3'd4:    bits = sh_reg;
            3'd3:    bits = {8'd0, sh_reg[31:8]};
            3'd2:    bits = {16'd0, sh_reg[31:16]};
            3'd1:    bits = {24'd0, sh_reg[31:24]};
            default: bits = '0;
        endcase
    end

endmodule

### hw/rtl/bgr_checker.sv
// ----------------------------------------------------------------------------
// Bitmap glyph renderer checker
// Port-level properties of the renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_glyph_renderer_macros.svh"

module bgr_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_ready,
    input  logic [bgr_pkg::CMD_W-1:0]     cmd_command,
    input  logic                          row_valid,
    input  logic                          row_ready,
    input  logic                          row_last,
    input  logic [bgr_pkg::COORD_W-1:0]   row_x
);
    import bgr_pkg::*;

    // A pending result must not be withdrawn before its transaction.
    `BGR_ASSERT_NEXT(a_row_hold, row_valid && !row_ready, row_valid, "row withdrawn while stalled")

    // No new command is taken while a character still has rows to come.
    `BGR_ASSERT_SAME(a_busy_mid_glyph, row_valid && !row_last, !cmd_ready, "command taken mid glyph")

    // A draw occupies the block for at least the following cycle.
    `BGR_ASSERT_NEXT(a_draw_busy, cmd_valid && cmd_ready && (cmd_command == CMD_DRAW), !cmd_ready,
        "ready directly after a draw")

    // After a load, cursor move or unused command the block is ready again in the next cycle.
    `BGR_ASSERT_NEXT(a_short_cmd, cmd_valid && cmd_ready && (cmd_command != CMD_DRAW), cmd_ready,
        "not ready after a single-cycle command")

    // All rows of one character share the same x position.
    `BGR_ASSERT_NEXT(a_row_x_same, row_valid && row_ready && !row_last, $stable(row_x),
        "row x changed within a glyph")

endmodule

bind bitmap_glyph_renderer bgr_checker u_bgr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_command (cmd.command),
    .row_valid   (rows.valid),
    .row_ready   (rows.ready),
    .row_last    (rows.last_row),
    .row_x       (rows.row_x)
);
